### hdl/ksu_pkg.sv
// shared widths, codes and sideband types of the kinematic steering unit
package ksu_pkg;

  // restoring square root: one result bit per cell
  localparam int RAD_W      = 64;
  localparam int ROOT_W     = 32;
  localparam int REM_W      = 33;
  localparam int SQRT_STEPS = ROOT_W;

  // restoring division: one quotient bit per cell
  localparam int DIV_W     = 32;
  localparam int QUO_W     = 31;
  localparam int DIV_STEPS = QUO_W;

  localparam int CFG_W = 31;
  localparam logic [CFG_W-1:0] MAX_PREDICTION_RST = 31'd6554;

  localparam logic CFG_MAX_SPEED      = 1'b0;
  localparam logic CFG_MAX_PREDICTION = 1'b1;

  typedef enum logic [1:0] {
    OP_SEEK   = 2'd0,
    OP_FLEE   = 2'd1,
    OP_PURSUE = 2'd2,
    OP_EVADE  = 2'd3
  } op_t;

  typedef struct packed {
    op_t                op;
    logic signed [31:0] tx;
    logic signed [31:0] ty;
    logic signed [31:0] tvx;
    logic signed [31:0] tvy;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
  } item_t;

  typedef struct packed {
    item_t item;
    logic  sh_d;
    logic  sh_s;
  } len_side_t;

  typedef struct packed {
    item_t item;
    logic  use_mp;
  } pred_side_t;

  typedef struct packed {
    logic nx;
    logic ny;
    logic degen;
  } out_side_t;

  typedef struct packed {
    logic [61:0] prod_x;
    logic [61:0] prod_y;
    out_side_t   flags;
  } norm_side_t;

endpackage

### hdl/ksu_sqrt_cell.sv
// one bit step of the restoring square root
module ksu_sqrt_cell (
  input  logic                       clk,
  input  logic [ksu_pkg::REM_W-1:0]  rem_in,
  input  logic [ksu_pkg::ROOT_W-1:0] root_in,
  input  logic [ksu_pkg::RAD_W-1:0]  rad_in,
  output logic [ksu_pkg::REM_W-1:0]  rem_out,
  output logic [ksu_pkg::ROOT_W-1:0] root_out,
  output logic [ksu_pkg::RAD_W-1:0]  rad_out
);
  import ksu_pkg::*;

  logic [REM_W+1:0] rem_t;
  logic [REM_W+1:0] trial;
  logic [REM_W+1:0] diff;
  logic             ge;

  always_comb begin
    rem_t = {rem_in, rad_in[RAD_W-1 -: 2]};
    trial = {1'b0, root_in, 2'b01};
    diff  = rem_t - trial;
    ge    = (rem_t >= trial);
  end

  always_ff @(posedge clk) begin
    rem_out  <= ge ? diff[REM_W-1:0] : rem_t[REM_W-1:0];
    root_out <= {root_in[ROOT_W-2:0], ge};
    rad_out  <= {rad_in[RAD_W-3:0], 2'b00};
  end

endmodule

### hdl/ksu_sqrt_chain.sv
// row of square root cells with valid and sideband carried alongside
module ksu_sqrt_chain #(
  parameter int NL = 1,
  parameter int SW = 1
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  logic [NL-1:0][ksu_pkg::RAD_W-1:0]   rad_in,
  input  logic [SW-1:0]                       side_in,
  output logic                                out_valid,
  output logic [NL-1:0][ksu_pkg::ROOT_W-1:0]  root_out,
  output logic [SW-1:0]                       side_out
);
  import ksu_pkg::*;

  logic [NL-1:0][REM_W-1:0]  rem   [SQRT_STEPS+1];
  logic [NL-1:0][ROOT_W-1:0] root  [SQRT_STEPS+1];
  logic [NL-1:0][RAD_W-1:0]  rad   [SQRT_STEPS+1];
  logic                      valid [SQRT_STEPS+1];
  logic [SW-1:0]             side  [SQRT_STEPS+1];

  assign rem[0]   = '0;
  assign root[0]  = '0;
  assign rad[0]   = rad_in;
  assign valid[0] = in_valid;
  assign side[0]  = side_in;

  for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_step
    for (genvar j = 0; j < NL; j++) begin : g_lane
      ksu_sqrt_cell u_cell (
        .clk      (clk),
        .rem_in   (rem[i][j]),
        .root_in  (root[i][j]),
        .rad_in   (rad[i][j]),
        .rem_out  (rem[i+1][j]),
        .root_out (root[i+1][j]),
        .rad_out  (rad[i+1][j])
      );
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        valid[i+1] <= 1'b0;
      end else begin
        valid[i+1] <= valid[i];
      end
    end

    always_ff @(posedge clk) begin
      side[i+1] <= side[i];
    end
  end

  assign out_valid = valid[SQRT_STEPS];
  assign root_out  = root[SQRT_STEPS];
  assign side_out  = side[SQRT_STEPS];

endmodule

### hdl/ksu_div_cell.sv
// one bit step of the restoring divider
module ksu_div_cell (
  input  logic                      clk,
  input  logic [ksu_pkg::DIV_W-1:0] rem_in,
  input  logic [ksu_pkg::QUO_W-1:0] num_in,
  input  logic [ksu_pkg::DIV_W-1:0] dvs_in,
  input  logic [ksu_pkg::QUO_W-1:0] quo_in,
  output logic [ksu_pkg::DIV_W-1:0] rem_out,
  output logic [ksu_pkg::QUO_W-1:0] num_out,
  output logic [ksu_pkg::DIV_W-1:0] dvs_out,
  output logic [ksu_pkg::QUO_W-1:0] quo_out
);
  import ksu_pkg::*;

  logic [DIV_W:0] rem_t;
  logic [DIV_W:0] diff;
  logic           ge;

  always_comb begin
    rem_t = {rem_in, num_in[QUO_W-1]};
    diff  = rem_t - {1'b0, dvs_in};
    ge    = (rem_t >= {1'b0, dvs_in});
  end

  always_ff @(posedge clk) begin
    rem_out <= ge ? diff[DIV_W-1:0] : rem_t[DIV_W-1:0];
    num_out <= {num_in[QUO_W-2:0], 1'b0};
    dvs_out <= dvs_in;
    quo_out <= {quo_in[QUO_W-2:0], ge};
  end

endmodule

### hdl/ksu_div_chain.sv
// row of divider cells with valid and sideband carried alongside
module ksu_div_chain #(
  parameter int NL = 1,
  parameter int SW = 1
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  input  logic [NL-1:0][ksu_pkg::DIV_W-1:0]  rem_in,
  input  logic [NL-1:0][ksu_pkg::QUO_W-1:0]  num_in,
  input  logic [NL-1:0][ksu_pkg::DIV_W-1:0]  dvs_in,
  input  logic [SW-1:0]                      side_in,
  output logic                               out_valid,
  output logic [NL-1:0][ksu_pkg::QUO_W-1:0]  quo_out,
  output logic [SW-1:0]                      side_out
);
  import ksu_pkg::*;

  logic [NL-1:0][DIV_W-1:0] rem   [DIV_STEPS+1];
  logic [NL-1:0][QUO_W-1:0] num   [DIV_STEPS+1];
  logic [NL-1:0][DIV_W-1:0] dvs   [DIV_STEPS+1];
  logic [NL-1:0][QUO_W-1:0] quo   [DIV_STEPS+1];
  logic                     valid [DIV_STEPS+1];
  logic [SW-1:0]            side  [DIV_STEPS+1];

  assign rem[0]   = rem_in;
  assign num[0]   = num_in;
  assign dvs[0]   = dvs_in;
  assign quo[0]   = '0;
  assign valid[0] = in_valid;
  assign side[0]  = side_in;

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_step
    for (genvar j = 0; j < NL; j++) begin : g_lane
      ksu_div_cell u_cell (
        .clk     (clk),
        .rem_in  (rem[i][j]),
        .num_in  (num[i][j]),
        .dvs_in  (dvs[i][j]),
        .quo_in  (quo[i][j]),
        .rem_out (rem[i+1][j]),
        .num_out (num[i+1][j]),
        .dvs_out (dvs[i+1][j]),
        .quo_out (quo[i+1][j])
      );
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        valid[i+1] <= 1'b0;
      end else begin
        valid[i+1] <= valid[i];
      end
    end

    always_ff @(posedge clk) begin
      side[i+1] <= side[i];
    end
  end

  assign out_valid = valid[DIV_STEPS];
  assign quo_out   = quo[DIV_STEPS];
  assign side_out  = side[DIV_STEPS];

endmodule

### hdl/kinematic_steering_unit.sv
// kinematic steering unit: seek, flee, pursue and evade steering vectors
// One item is taken at every clock edge with start high (busy is always low), and its
// result is strobed by done, one result per item in order, after two passes through
// a 32-cell square root row and a 31-cell divider row: distance and speed,
// prediction time, then length and the two scaled components. The result is shown
// for one cycle only and cannot be held off, so the receiver must take it on the
// cycle done is high.
module kinematic_steering_unit (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                op,
  input  logic signed [31:0]        target_x,
  input  logic signed [31:0]        target_y,
  input  logic signed [31:0]        target_vx,
  input  logic signed [31:0]        target_vy,
  input  logic signed [31:0]        char_x,
  input  logic signed [31:0]        char_y,
  input  logic signed [31:0]        char_vx,
  input  logic signed [31:0]        char_vy,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [ksu_pkg::CFG_W-1:0] cfg_data,
  output logic                      done,
  output logic signed [31:0]        linear_x,
  output logic signed [31:0]        linear_y,
  output logic                      degenerate
);
  import ksu_pkg::*;

  localparam int LEN_SW  = $bits(len_side_t);
  localparam int PRED_SW = $bits(pred_side_t);
  localparam int NORM_SW = $bits(norm_side_t);
  localparam int OUT_SW  = $bits(out_side_t);
  localparam int NSTG    = 5;

  function automatic logic [32:0] mag33(logic [32:0] v);
    return v[32] ? (~v + 33'd1) : v;
  endfunction

  function automatic logic [30:0] prescale(logic [32:0] v, logic big);
    return big ? v[32:2] : v[30:0];
  endfunction

  function automatic logic [31:0] sat32(logic [48:0] r);
    if (r[48] == 1'b0 && r[47:31] != '0) begin
      return 32'h7fff_ffff;
    end else if (r[48] == 1'b1 && r[47:31] != '1) begin
      return 32'h8000_0000;
    end
    return r[31:0];
  endfunction

  logic [CFG_W-1:0] speed_limit;
  logic [CFG_W-1:0] look_limit;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      speed_limit <= '0;
      look_limit  <= MAX_PREDICTION_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MAX_SPEED:      speed_limit <= cfg_data;
        CFG_MAX_PREDICTION: look_limit  <= cfg_data;
        default:            speed_limit <= speed_limit;
      endcase
    end
  end

  // stage 1: capture the transaction
  logic               v1;
  item_t              item1;
  logic signed [31:0] cvx1, cvy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      item1.op  <= op_t'(op);
      item1.tx  <= target_x;
      item1.ty  <= target_y;
      item1.tvx <= target_vx;
      item1.tvy <= target_vy;
      item1.cx  <= char_x;
      item1.cy  <= char_y;
      cvx1      <= char_vx;
      cvy1      <= char_vy;
    end
  end

  // stage 2: component magnitudes, prescaled below 2^31
  logic [32:0] dmx, dmy, smx, smy;
  logic        big_d, big_s;
  logic        v2;
  len_side_t   side2;
  logic [30:0] da2, db2, sa2, sb2;

  always_comb begin
    dmx   = mag33({item1.tx[31], item1.tx} - {item1.cx[31], item1.cx});
    dmy   = mag33({item1.ty[31], item1.ty} - {item1.cy[31], item1.cy});
    smx   = mag33({cvx1[31], cvx1});
    smy   = mag33({cvy1[31], cvy1});
    big_d = (dmx[32:31] != 2'b00) || (dmy[32:31] != 2'b00);
    big_s = (smx[32:31] != 2'b00) || (smy[32:31] != 2'b00);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    da2        <= prescale(dmx, big_d);
    db2        <= prescale(dmy, big_d);
    sa2        <= prescale(smx, big_s);
    sb2        <= prescale(smy, big_s);
    side2.item <= item1;
    side2.sh_d <= big_d;
    side2.sh_s <= big_s;
  end

  // stage 3: squares
  logic        v3;
  len_side_t   side3;
  logic [61:0] sqda3, sqdb3, sqsa3, sqsb3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    sqda3 <= da2 * da2;
    sqdb3 <= db2 * db2;
    sqsa3 <= sa2 * sa2;
    sqsb3 <= sb2 * sb2;
    side3 <= side2;
  end

  // stage 4: radicands
  logic                  v4;
  len_side_t             side4;
  logic [1:0][RAD_W-1:0] rad4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    rad4[0] <= {1'b0, {1'b0, sqda3} + {1'b0, sqdb3}};
    rad4[1] <= {1'b0, {1'b0, sqsa3} + {1'b0, sqsb3}};
    side4   <= side3;
  end

  // distance and speed
  logic                   va;
  logic [1:0][ROOT_W-1:0] roota;
  logic [LEN_SW-1:0]      sidea_vec;
  len_side_t              sidea;

  ksu_sqrt_chain #(.NL(2), .SW(LEN_SW)) u_len_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v4),
    .rad_in    (rad4),
    .side_in   (side4),
    .out_valid (va),
    .root_out  (roota),
    .side_out  (sidea_vec)
  );

  assign sidea = len_side_t'(sidea_vec);

  // stage 5: speed times look-ahead
  logic [33:0] dist_c, speed_c;
  logic        v5;
  item_t       item5;
  logic [33:0] dist5;
  logic [31:0] speed5;
  logic [62:0] prod5;

  always_comb begin
    dist_c  = sidea.sh_d ? {roota[0], 2'b00} : {2'b00, roota[0]};
    speed_c = sidea.sh_s ? {roota[1], 2'b00} : {2'b00, roota[1]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else begin
      v5 <= va;
    end
  end

  always_ff @(posedge clk) begin
    dist5  <= dist_c;
    speed5 <= speed_c[31:0];
    prod5  <= speed_c[31:0] * look_limit;
    item5  <= sidea.item;
  end

  // prediction time divide: (dist << 16) / speed
  logic [49:0]             num50;
  pred_side_t              pside_in;
  logic [0:0][DIV_W-1:0]   prem_in, pdvs_in;
  logic [0:0][QUO_W-1:0]   pnum_in;

  always_comb begin
    num50           = {dist5, 16'h0000};
    prem_in[0]      = {13'b0, num50[49:31]};
    pnum_in[0]      = num50[30:0];
    pdvs_in[0]      = speed5;
    pside_in.item   = item5;
    pside_in.use_mp = (prod5 <= {13'b0, num50});
  end

  logic                  vb;
  logic [0:0][QUO_W-1:0] quob;
  logic [PRED_SW-1:0]    sideb_vec;
  pred_side_t            sideb;

  ksu_div_chain #(.NL(1), .SW(PRED_SW)) u_pred_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v5),
    .rem_in    (prem_in),
    .num_in    (pnum_in),
    .dvs_in    (pdvs_in),
    .side_in   (pside_in),
    .out_valid (vb),
    .quo_out   (quob),
    .side_out  (sideb_vec)
  );

  assign sideb = pred_side_t'(sideb_vec);

  // stage 6: target displacement over the look-ahead
  logic        pred_op;
  logic [30:0] t_c;
  logic [31:0] vxm, vym;
  logic [62:0] mx_c, my_c;
  logic        v6;
  item_t       item6;
  logic [46:0] mx6, my6;

  always_comb begin
    pred_op = (sideb.item.op == OP_PURSUE) || (sideb.item.op == OP_EVADE);
    if (!pred_op) begin
      t_c = '0;
    end else if (sideb.use_mp) begin
      t_c = look_limit;
    end else begin
      t_c = quob[0];
    end
    vxm  = sideb.item.tvx[31] ? (~sideb.item.tvx + 32'd1) : sideb.item.tvx;
    vym  = sideb.item.tvy[31] ? (~sideb.item.tvy + 32'd1) : sideb.item.tvy;
    mx_c = vxm * t_c;
    my_c = vym * t_c;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else begin
      v6 <= vb;
    end
  end

  always_ff @(posedge clk) begin
    mx6   <= mx_c[62:16];
    my6   <= my_c[62:16];
    item6 <= sideb.item;
  end

  // stage 7: predicted target, saturated
  logic [48:0]        rx_c, ry_c;
  logic               v7;
  op_t                op7;
  logic signed [31:0] px7, py7, cx7, cy7;

  always_comb begin
    rx_c = item6.tvx[31] ? ({{17{item6.tx[31]}}, item6.tx} - {2'b00, mx6})
                         : ({{17{item6.tx[31]}}, item6.tx} + {2'b00, mx6});
    ry_c = item6.tvy[31] ? ({{17{item6.ty[31]}}, item6.ty} - {2'b00, my6})
                         : ({{17{item6.ty[31]}}, item6.ty} + {2'b00, my6});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else begin
      v7 <= v6;
    end
  end

  always_ff @(posedge clk) begin
    px7 <= sat32(rx_c);
    py7 <= sat32(ry_c);
    cx7 <= item6.cx;
    cy7 <= item6.cy;
    op7 <= item6.op;
  end

  // stage 8: direction magnitudes and signs
  logic        away;
  logic [32:0] dx_c, dy_c;
  logic        v8;
  logic [32:0] ax8, ay8;
  out_side_t   flags8;

  always_comb begin
    away = (op7 == OP_FLEE) || (op7 == OP_EVADE);
    dx_c = away ? ({cx7[31], cx7} - {px7[31], px7}) : ({px7[31], px7} - {cx7[31], cx7});
    dy_c = away ? ({cy7[31], cy7} - {py7[31], py7}) : ({py7[31], py7} - {cy7[31], cy7});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v8 <= 1'b0;
    end else begin
      v8 <= v7;
    end
  end

  always_ff @(posedge clk) begin
    ax8          <= mag33(dx_c);
    ay8          <= mag33(dy_c);
    flags8.nx    <= dx_c[32];
    flags8.ny    <= dy_c[32];
    flags8.degen <= (dx_c == '0) && (dy_c == '0);
  end

  // stage 9: bring the larger magnitude below 2^31
  logic [32:0] or8;
  logic [30:0] na    [NSTG+1];
  logic [30:0] nb    [NSTG+1];
  logic        nv    [NSTG+1];
  out_side_t   nflag [NSTG+1];

  assign or8 = ax8 | ay8;

  always_ff @(posedge clk) begin
    if (rst) begin
      nv[0] <= 1'b0;
    end else begin
      nv[0] <= v8;
    end
  end

  always_ff @(posedge clk) begin
    if (or8[32]) begin
      na[0] <= ax8[32:2];
      nb[0] <= ay8[32:2];
    end else if (or8[31]) begin
      na[0] <= ax8[31:1];
      nb[0] <= ay8[31:1];
    end else begin
      na[0] <= ax8[30:0];
      nb[0] <= ay8[30:0];
    end
    nflag[0] <= flags8;
  end

  // left shifts by 16, 8, 4, 2, 1 until the larger lies in [2^30, 2^31)
  for (genvar k = 0; k < NSTG; k++) begin : g_norm
    localparam int SH = 16 >> k;
    logic [30:0] orv;
    logic        up;

    assign orv = na[k] | nb[k];
    assign up  = (orv[30 -: SH] == '0);

    always_ff @(posedge clk) begin
      if (rst) begin
        nv[k+1] <= 1'b0;
      end else begin
        nv[k+1] <= nv[k];
      end
    end

    always_ff @(posedge clk) begin
      na[k+1]    <= up ? (na[k] << SH) : na[k];
      nb[k+1]    <= up ? (nb[k] << SH) : nb[k];
      nflag[k+1] <= nflag[k];
    end
  end

  // stage 15: squares and scaled components
  logic        v15;
  logic [61:0] sqx15, sqy15;
  norm_side_t  side15;

  always_ff @(posedge clk) begin
    if (rst) begin
      v15 <= 1'b0;
    end else begin
      v15 <= nv[NSTG];
    end
  end

  always_ff @(posedge clk) begin
    sqx15         <= na[NSTG] * na[NSTG];
    sqy15         <= nb[NSTG] * nb[NSTG];
    side15.prod_x <= na[NSTG] * speed_limit;
    side15.prod_y <= nb[NSTG] * speed_limit;
    side15.flags  <= nflag[NSTG];
  end

  // stage 16: length radicand
  logic                  v16;
  logic [0:0][RAD_W-1:0] rad16;
  norm_side_t            side16;

  always_ff @(posedge clk) begin
    if (rst) begin
      v16 <= 1'b0;
    end else begin
      v16 <= v15;
    end
  end

  always_ff @(posedge clk) begin
    rad16[0] <= {1'b0, {1'b0, sqx15} + {1'b0, sqy15}};
    side16   <= side15;
  end

  logic                   vc;
  logic [0:0][ROOT_W-1:0] rootc;
  logic [NORM_SW-1:0]     sidec_vec;
  norm_side_t             sidec;

  ksu_sqrt_chain #(.NL(1), .SW(NORM_SW)) u_norm_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v16),
    .rad_in    (rad16),
    .side_in   (side16),
    .out_valid (vc),
    .root_out  (rootc),
    .side_out  (sidec_vec)
  );

  assign sidec = norm_side_t'(sidec_vec);

  // component * speed limit / length, both lanes
  logic [1:0][DIV_W-1:0] orem_in, odvs_in;
  logic [1:0][QUO_W-1:0] onum_in;

  always_comb begin
    orem_in[0] = {1'b0, sidec.prod_x[61:31]};
    orem_in[1] = {1'b0, sidec.prod_y[61:31]};
    onum_in[0] = sidec.prod_x[30:0];
    onum_in[1] = sidec.prod_y[30:0];
    odvs_in[0] = rootc[0];
    odvs_in[1] = rootc[0];
  end

  logic                  vd;
  logic [1:0][QUO_W-1:0] quod;
  logic [OUT_SW-1:0]     sided_vec;
  out_side_t             sided;

  ksu_div_chain #(.NL(2), .SW(OUT_SW)) u_out_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (vc),
    .rem_in    (orem_in),
    .num_in    (onum_in),
    .dvs_in    (odvs_in),
    .side_in   (sidec.flags),
    .out_valid (vd),
    .quo_out   (quod),
    .side_out  (sided_vec)
  );

  assign sided = out_side_t'(sided_vec);

  // output transaction
  logic [31:0] qx_c, qy_c;

  always_comb begin
    qx_c = {1'b0, quod[0]};
    qy_c = {1'b0, quod[1]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vd;
    end
  end

  always_ff @(posedge clk) begin
    if (sided.degen) begin
      linear_x <= '0;
      linear_y <= '0;
    end else begin
      linear_x <= sided.nx ? (~qx_c + 32'd1) : qx_c;
      linear_y <= sided.ny ? (~qy_c + 32'd1) : qy_c;
    end
    degenerate <= sided.degen;
  end

endmodule

### tb/steering_checker.sv
// checker for the kinematic steering unit: predicts steering vectors and compares results
`timescale 1ns / 100ps

module steering_checker (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic                      busy,
  input  logic [1:0]                op,
  input  logic signed [31:0]        target_x,
  input  logic signed [31:0]        target_y,
  input  logic signed [31:0]        target_vx,
  input  logic signed [31:0]        target_vy,
  input  logic signed [31:0]        char_x,
  input  logic signed [31:0]        char_y,
  input  logic signed [31:0]        char_vx,
  input  logic signed [31:0]        char_vy,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [ksu_pkg::CFG_W-1:0] cfg_data,
  input  logic                      done,
  input  logic signed [31:0]        linear_x,
  input  logic signed [31:0]        linear_y,
  input  logic                      degenerate,
  output int                        fail_count,
  output int                        pending
);
  import ksu_pkg::*;

  typedef struct {
    logic [31:0] lx;
    logic [31:0] ly;
    logic        degen;
  } steer_t;

  steer_t      expected_q[$];
  logic [63:0] speed_reg;
  logic [63:0] lookahead_reg;

  assign pending = expected_q.size();

  function automatic logic [63:0] int_sqrt(logic [63:0] n);
    logic [63:0] res;
    logic [63:0] b;
    res = 0;
    b   = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n   = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] abs64(longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic [63:0] vec_length(logic [63:0] a, logic [63:0] b);
    int s;
    s = 0;
    if (a >= (64'd1 << 31) || b >= (64'd1 << 31)) begin
      a = a >> 2;
      b = b >> 2;
      s = 2;
    end
    return int_sqrt(a * a + b * b) << s;
  endfunction

  function automatic longint advance(longint pos, longint vel, logic [63:0] t);
    logic [63:0] m;
    longint      r;
    m = (abs64(vel) * t) >> 16;
    r = vel < 0 ? pos - longint'(m) : pos + longint'(m);
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    if (r < -64'sd2147483648) r = -64'sd2147483648;
    return r;
  endfunction

  function automatic steer_t direct(longint dx, longint dy);
    steer_t      s;
    logic [63:0] ax, ay, len, mx, my;
    ax = abs64(dx);
    ay = abs64(dy);
    if (ax == 0 && ay == 0) begin
      s.lx = 0; s.ly = 0; s.degen = 1'b1;
      return s;
    end
    while (ax >= (64'd1 << 31) || ay >= (64'd1 << 31)) begin
      ax = ax >> 1;
      ay = ay >> 1;
    end
    while (ax < (64'd1 << 30) && ay < (64'd1 << 30)) begin
      ax = ax << 1;
      ay = ay << 1;
    end
    len  = int_sqrt(ax * ax + ay * ay);
    mx   = (ax * speed_reg) / len;
    my   = (ay * speed_reg) / len;
    s.lx = dx < 0 ? 32'(-mx) : 32'(mx);
    s.ly = dy < 0 ? 32'(-my) : 32'(my);
    s.degen = 1'b0;
    return s;
  endfunction

  function automatic steer_t steering_vector(op_t o, longint tx, longint ty, longint tvx,
                                             longint tvy, longint cx, longint cy,
                                             longint cvx, longint cvy);
    logic [63:0] range_len, spd, t;
    if (o == OP_PURSUE || o == OP_EVADE) begin
      range_len = vec_length(abs64(tx - cx), abs64(ty - cy));
      spd       = vec_length(abs64(cvx), abs64(cvy));
      if (spd * lookahead_reg <= (range_len << 16)) t = lookahead_reg;
      else t = (range_len << 16) / spd;
      tx = advance(tx, tvx, t);
      ty = advance(ty, tvy, t);
    end
    if (o == OP_SEEK || o == OP_PURSUE) return direct(tx - cx, ty - cy);
    return direct(cx - tx, cy - ty);
  endfunction

  always @(posedge clk) begin
    steer_t e;
    if (rst) begin
      speed_reg     <= 0;
      lookahead_reg <= 64'(MAX_PREDICTION_RST);
      fail_count    <= 0;
      expected_q.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_MAX_SPEED) speed_reg <= 64'(cfg_data);
        else lookahead_reg <= 64'(cfg_data);
      end
      if (start && !busy)
        expected_q.push_back(steering_vector(op_t'(op), target_x, target_y, target_vx,
                                             target_vy, char_x, char_y, char_vx, char_vy));
      if (done) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected transaction x=%h y=%h d=%b", $time, linear_x, linear_y,
                   degenerate);
          fail_count <= fail_count + 1;
        end else begin
          e = expected_q.pop_front();
          if (e.lx !== linear_x || e.ly !== linear_y || e.degen !== degenerate) begin
            $display("%0t: mismatch expected x=%h y=%h d=%b actual x=%h y=%h d=%b", $time,
                     e.lx, e.ly, e.degen, linear_x, linear_y, degenerate);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

### tb/testbench.sv
// top of the steering unit testbench: stimulus, configuration phases and verdict
`timescale 1ns / 100ps

module testbench;
  import ksu_pkg::*;

  localparam int LATENCY   = 143;
  localparam int WDOG_MAX  = 2000;

  logic clk, rst, start, busy, cfg_we, cfg_index, done, degenerate;
  logic [1:0] op;
  logic signed [31:0] target_x, target_y, target_vx, target_vy;
  logic signed [31:0] char_x, char_y, char_vx, char_vy, linear_x, linear_y;
  logic [CFG_W-1:0] cfg_data;
  int fail_count, pending, idle_cycles;

  kinematic_steering_unit u_top (.*);
  steering_checker u_chk (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_MAX) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic write_reg(logic idx, logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we = 1; cfg_index = idx; cfg_data = val;
    @(negedge clk);
    cfg_we = 0;
  endtask

  // waits out all in-flight transactions
  task automatic drain();
    while (pending != 0) @(negedge clk);
    repeat (LATENCY + 5) @(negedge clk);
  endtask

  function automatic logic [31:0] rand_coord(int mode);
    case (mode)
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
      2: return 32'($signed($urandom_range(0, 600)) - 300) << 16;
      default: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
    endcase
  endfunction

  task automatic send(logic [1:0] o, logic [31:0] tx, ty, tvx, tvy, cx, cy, cvx, cvy,
                      bit gaps);
    if (gaps) repeat ($urandom_range(0, 3)) @(negedge clk);
    op = o; target_x = tx; target_y = ty; target_vx = tvx; target_vy = tvy;
    char_x = cx; char_y = cy; char_vx = cvx; char_vy = cvy;
    start = 1;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
    start = 0;
  endtask

  task automatic random_item(bit gaps);
    int m;
    logic [31:0] tx, ty, cx, cy;
    m  = $urandom_range(0, 9) == 0 ? 0 : $urandom_range(1, 3);
    tx = rand_coord(m); ty = rand_coord(m);
    if ($urandom_range(0, 15) == 0) begin
      cx = tx; cy = ty;
    end else begin
      cx = rand_coord(m); cy = rand_coord(m);
    end
    send(op_t'($urandom_range(0, 3)), tx, ty, rand_coord($urandom_range(0, 3)),
         rand_coord($urandom_range(0, 3)), cx, cy, rand_coord($urandom_range(0, 3)),
         rand_coord($urandom_range(0, 3)), gaps);
  endtask

  initial begin
    logic [CFG_W-1:0] speeds[5];
    logic [CFG_W-1:0] looks[5];
    rst = 1; start = 0; cfg_we = 0; cfg_index = 0; cfg_data = 0; op = OP_SEEK;
    target_x = 0; target_y = 0; target_vx = 0; target_vy = 0;
    char_x = 0; char_y = 0; char_vx = 0; char_vy = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // reset values: zero speed, default look-ahead
    send(OP_PURSUE, 32'h10000, 0, 32'h10000, 0, 0, 0, 32'h10000, 0, 0);
    drain();
    write_reg(CFG_MAX_SPEED, 31'h10000);
    // directed: every op, extremes, zero direction, saturation
    send(OP_SEEK, 32'h7fffffff, 32'h7fffffff, 0, 0, 32'h80000000, 32'h80000000, 0, 0, 0);
    send(OP_FLEE, 32'h80000000, 32'h7fffffff, 0, 0, 32'h7fffffff, 32'h80000000, 0, 0, 0);
    send(OP_SEEK, 32'h1234, 32'h5678, 0, 0, 32'h1234, 32'h5678, 0, 0, 0);
    send(OP_FLEE, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    send(OP_PURSUE, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000,
         0, 0, 0, 0, 0);
    send(OP_EVADE, 32'h100000, 0, 32'h80000000, 32'h7fffffff, 0, 0,
         32'h7fffffff, 32'h80000000, 0);
    send(OP_PURSUE, 32'h10000, 0, 32'hfff00000, 0, 0, 0, 32'h100000, 0, 0);
    send(OP_EVADE, 5, 0, 0, 0, 0, 0, 0, 0, 0);
    send(OP_PURSUE, 0, 0, 32'h10000, 0, 0, 0, 0, 0, 0);
    send(OP_SEEK, 32'hffffffff, 1, 0, 0, 0, 0, 0, 0, 0);
    send(OP_EVADE, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
         32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 0);
    drain();

    speeds = '{31'h7fffffff, 31'd0, 31'd1, 31'h00050000, 31'($urandom())};
    looks  = '{31'h7fffffff, 31'd0, 31'd1, 31'h00020000, 31'($urandom())};
    for (int p = 0; p < 5; p++) begin
      write_reg(CFG_MAX_SPEED, speeds[p]);
      write_reg(CFG_MAX_PREDICTION, looks[p]);
      for (int i = 0; i < 90; i++) random_item(p % 2 == 0 || i > 45);
      drain();
    end

    if (fail_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule
